>>> rtl/foc_pkg.sv
package foc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 16;
  localparam int BUS_W    = 15;
  localparam int DUTY_W   = 16;
  localparam int IN_W     = 112;
  localparam int OUT_W    = 80;

  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 34;
  localparam int ZW           = 33;
  localparam int MAG_W        = 37;
  localparam int QUO_W        = 38;
  localparam int VW           = 58;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [30:0]   INV_SQRT3   = 31'sd619925131;
  localparam logic signed [17:0]   SQRT3_HALF  = 18'sd56756;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  function automatic logic [ZW-1:0] atan_step(input logic [3:0] i);
    logic [ZW-1:0] r;
    unique case (i)
      4'd0:  r = 33'h020000000;
      4'd1:  r = 33'h012E4051E;
      4'd2:  r = 33'h009FB385B;
      4'd3:  r = 33'h0051111D4;
      4'd4:  r = 33'h0028B0D43;
      4'd5:  r = 33'h00145D7E1;
      4'd6:  r = 33'h000A2F61E;
      4'd7:  r = 33'h000517C55;
      4'd8:  r = 33'h00028BE53;
      4'd9:  r = 33'h000145F2F;
      4'd10: r = 33'h0000A2F98;
      4'd11: r = 33'h0000517CC;
      4'd12: r = 33'h000028BE6;
      4'd13: r = 33'h0000145F3;
      4'd14: r = 33'h00000A2FA;
      default: r = 33'h00000517D;
    endcase
    return r;
  endfunction

  function automatic sample_t sat_sample(input logic signed [22:0] v);
    sample_t r;
    if (v > 23'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -23'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [DUTY_W-1:0] to_duty(input logic signed [VW-1:0] v,
                                                input logic signed [VW-1:0] vcom);
    logic signed [59:0] d;
    logic [52:0] t;
    logic [DUTY_W-1:0] r;
    d = 60'(v) - 60'(vcom) + 60'sh800000000;
    t = {1'b0, d[35:0], 16'h0000} - {17'd0, d[35:0]} + 53'h0800000000;
    if (d <= 60'sd0) begin
      r = '0;
    end else if (d >= 60'sh1000000000) begin
      r = '1;
    end else begin
      r = t[51:36];
    end
    return r;
  endfunction

endpackage

>>> rtl/foc_cordic.sv
module foc_cordic #(
  parameter int SIDE_W = 95
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [foc_pkg::ANGLE_W-1:0]           angle,
  input  logic [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  output logic signed [foc_pkg::CW-1:0]         sin_q30,
  output logic signed [foc_pkg::CW-1:0]         cos_q30,
  output logic [SIDE_W-1:0]                     out_side
);
  import foc_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic                 val  [0:N];
  logic signed [CW-1:0] cx   [0:N];
  logic signed [CW-1:0] cy   [0:N];
  logic signed [ZW-1:0] cz   [0:N];
  logic [1:0]           quad [0:N];
  logic [SIDE_W-1:0]    side [0:N];

  assign val[0]  = in_valid;
  assign cx[0]   = CORDIC_GAIN;
  assign cy[0]   = '0;
  assign cz[0]   = {3'b000, angle[13:0], 16'h0000};
  assign quad[0] = angle[15:14];
  assign side[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        val[i+1] <= 1'b0;
      end else if (en) begin
        val[i+1] <= val[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_step(4'(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_step(4'(i));
        end
        quad[i+1] <= quad[i];
        side[i+1] <= side[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= val[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side[N];
      unique case (quad[N])
        2'd0: begin
          cos_q30 <= cx[N];
          sin_q30 <= cy[N];
        end
        2'd1: begin
          cos_q30 <= -cy[N];
          sin_q30 <= cx[N];
        end
        2'd2: begin
          cos_q30 <= -cx[N];
          sin_q30 <= -cy[N];
        end
        default: begin
          cos_q30 <= cy[N];
          sin_q30 <= -cx[N];
        end
      endcase
    end
  end

endmodule

>>> rtl/foc_div.sv
module foc_div #(
  parameter int SIDE_W = 35
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [foc_pkg::MAG_W-1:0]     num_a,
  input  logic [foc_pkg::MAG_W-1:0]     num_b,
  input  logic [foc_pkg::BUS_W-1:0]     den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [foc_pkg::MAG_W-1:0]     quo_a,
  output logic [foc_pkg::MAG_W-1:0]     quo_b,
  output logic [SIDE_W-1:0]             out_side
);
  import foc_pkg::*;

  localparam int N = MAG_W;

  logic              val  [0:N];
  logic [BUS_W-1:0]  ra   [0:N];
  logic [BUS_W-1:0]  rb   [0:N];
  logic [MAG_W-1:0]  da   [0:N];
  logic [MAG_W-1:0]  db   [0:N];
  logic [BUS_W-1:0]  dv   [0:N];
  logic [SIDE_W-1:0] side [0:N];

  assign val[0]  = in_valid;
  assign ra[0]   = '0;
  assign rb[0]   = '0;
  assign da[0]   = num_a;
  assign db[0]   = num_b;
  assign dv[0]   = den;
  assign side[0] = in_side;

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [BUS_W:0] sa, sb;
    logic           ga, gb;

    assign sa = {ra[i], da[i][MAG_W-1]};
    assign sb = {rb[i], db[i][MAG_W-1]};
    assign ga = sa >= {1'b0, dv[i]};
    assign gb = sb >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        val[i+1] <= 1'b0;
      end else if (en) begin
        val[i+1] <= val[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra[i+1]   <= ga ? BUS_W'(sa - {1'b0, dv[i]}) : sa[BUS_W-1:0];
        rb[i+1]   <= gb ? BUS_W'(sb - {1'b0, dv[i]}) : sb[BUS_W-1:0];
        da[i+1]   <= {da[i][MAG_W-2:0], ga};
        db[i+1]   <= {db[i][MAG_W-2:0], gb};
        dv[i+1]   <= dv[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = val[N];
  assign quo_a     = da[N];
  assign quo_b     = db[N];
  assign out_side  = side[N];

endmodule

>>> rtl/foc_transform_midpoint_svpwm_core.sv
// field oriented control transform core
// input stream s_*: one transfer per control sample carrying angle, three
// phase currents, d/q voltage commands and bus voltage
// output stream m_*: current_d, current_q and three duty values
// each input transfer gives exactly one output transfer, in order
// pipeline from input transfer to output valid: 17 cordic stages,
// 4 clarke/park stages, 37 divider stages, 3 modulation stages, output
// throughput: one item per clock, limited by nothing but the output side
// the whole pipeline advances together; when m_tready is low with an output
// waiting, every stage holds and s_tready drops in the same cycle
// reset clears all valid bits; payload registers keep whatever they held
// zero bus voltage gives the half period on all three duties
module foc_transform_midpoint_svpwm_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // angle, current_a, current_b, current_c, volt_d_cmd, volt_q_cmd, bus_volt
  input  logic [foc_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // current_d, current_q, duty_a, duty_b, duty_c
  output logic [foc_pkg::OUT_W-1:0]   m_tdata
);
  import foc_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // cordic front end
  logic                 c_val;
  logic signed [CW-1:0] sn, cs;
  logic [94:0]          c_side;

  foc_cordic #(.SIDE_W(95)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .angle     (s_tdata[15:0]),
    .in_side   (s_tdata[110:16]),
    .out_valid (c_val),
    .sin_q30   (sn),
    .cos_q30   (cs),
    .out_side  (c_side)
  );

  sample_t          ia, ib, ic, vd, vq;
  logic [BUS_W-1:0] bus;
  assign ia  = c_side[15:0];
  assign ib  = c_side[31:16];
  assign ic  = c_side[47:32];
  assign vd  = c_side[63:48];
  assign vq  = c_side[79:64];
  assign bus = c_side[94:80];

  // t1: products
  logic                 v1;
  logic signed [47:0]   p_beta;
  logic signed [23:0]   ax1;
  logic signed [49:0]   vdcs, vqsn, vdsn, vqcs;
  logic signed [CW-1:0] sn1, cs1;
  logic [BUS_W-1:0]     bus1;
  logic signed [16:0]   cdiff;
  assign cdiff = 17'(ib) - 17'(ic);

  // t2: clarke rounding, voltage sums
  logic                 v2;
  logic signed [25:0]   bx2;
  logic signed [23:0]   ax2;
  logic signed [CW-1:0] sn2, cs2;
  logic [MAG_W-1:0]     mag_a2, mag_b2;
  logic                 neg_a2, neg_b2;
  logic [BUS_W-1:0]     bus2;
  logic signed [47:0]   pb_rnd;
  logic signed [50:0]   num_a, num_b, abs_a, abs_b;
  assign pb_rnd = p_beta + 48'sd2097152;
  assign num_a  = 51'(vdcs) - 51'(vqsn);
  assign num_b  = 51'(vdsn) + 51'(vqcs);
  assign abs_a  = num_a[50] ? -num_a : num_a;
  assign abs_b  = num_b[50] ? -num_b : num_b;

  // t3: park products
  logic               v3;
  logic signed [57:0] pa_c, pa_s;
  logic signed [59:0] pb_s, pb_c;
  logic [MAG_W-1:0]   mag_a3, mag_b3;
  logic               neg_a3, neg_b3;
  logic [BUS_W-1:0]   bus3;

  // t4: park sums
  logic               v4;
  sample_t            id4, iq4;
  logic [MAG_W-1:0]   mag_a4, mag_b4;
  logic               neg_a4, neg_b4;
  logic [BUS_W-1:0]   bus4;
  logic signed [60:0] sum_d, sum_q;
  assign sum_d = 61'(pa_c) + 61'(pb_s) + 61'sh2000000000;
  assign sum_q = 61'(pb_c) - 61'(pa_s) + 61'sh2000000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= c_val;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_beta <= cdiff * INV_SQRT3;
      ax1    <= {ia, 8'h00};
      vdcs   <= vd * cs;
      vqsn   <= vq * sn;
      vdsn   <= vd * sn;
      vqcs   <= vq * cs;
      sn1    <= sn;
      cs1    <= cs;
      bus1   <= bus;

      bx2    <= pb_rnd[47:22];
      ax2    <= ax1;
      sn2    <= sn1;
      cs2    <= cs1;
      mag_a2 <= abs_a[46:10];
      mag_b2 <= abs_b[46:10];
      neg_a2 <= num_a[50];
      neg_b2 <= num_b[50];
      bus2   <= bus1;

      pa_c   <= ax2 * cs2;
      pa_s   <= ax2 * sn2;
      pb_s   <= bx2 * sn2;
      pb_c   <= bx2 * cs2;
      mag_a3 <= mag_a2;
      mag_b3 <= mag_b2;
      neg_a3 <= neg_a2;
      neg_b3 <= neg_b2;
      bus3   <= bus2;

      id4    <= sat_sample(sum_d[60:38]);
      iq4    <= sat_sample(sum_q[60:38]);
      mag_a4 <= mag_a3;
      mag_b4 <= mag_b3;
      neg_a4 <= neg_a3;
      neg_b4 <= neg_b3;
      bus4   <= bus3;
    end
  end

  // normalize by bus voltage
  logic             dv_val;
  logic [MAG_W-1:0] quo_a, quo_b;
  logic [34:0]      d_side;

  foc_div #(.SIDE_W(35)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num_a     (mag_a4),
    .num_b     (mag_b4),
    .den       (bus4),
    .in_side   ({bus4 == '0, neg_b4, neg_a4, iq4, id4}),
    .out_valid (dv_val),
    .quo_a     (quo_a),
    .quo_b     (quo_b),
    .out_side  (d_side)
  );

  logic signed [QUO_W-1:0] na, nb;
  assign na = d_side[34] ? '0 :
              (d_side[32] ? -{1'b0, quo_a} : {1'b0, quo_a});
  assign nb = d_side[34] ? '0 :
              (d_side[33] ? -{1'b0, quo_b} : {1'b0, quo_b});

  // t5..t8: phase voltages, midpoint injection, duty
  logic               v5, v6, v7, v8;
  logic signed [VW-1:0] va5, nh5, nbs5;
  logic signed [VW-1:0] va6, vb6, vc6;
  logic signed [VW-1:0] va7, vb7, vc7, vcom7;
  sample_t            id5, iq5, id6, iq6, id7, iq7;
  logic signed [VW-1:0] vmax, vmin;
  logic signed [VW:0]   vsum;

  always_comb begin
    vmax = va6;
    if (vb6 > vmax) vmax = vb6;
    if (vc6 > vmax) vmax = vc6;
    vmin = va6;
    if (vb6 < vmin) vmin = vb6;
    if (vc6 < vmin) vmin = vc6;
  end
  assign vsum = (59'(vmax) + 59'(vmin)) >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v5 <= dv_val;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va5   <= VW'(na) <<< 16;
      nh5   <= VW'(na) <<< 15;
      nbs5  <= VW'(nb) * VW'(SQRT3_HALF);
      id5   <= d_side[15:0];
      iq5   <= d_side[31:16];

      va6   <= va5;
      vb6   <= nbs5 - nh5;
      vc6   <= -nh5 - nbs5;
      id6   <= id5;
      iq6   <= iq5;

      va7   <= va6;
      vb7   <= vb6;
      vc7   <= vc6;
      vcom7 <= vsum[VW-1:0];
      id7   <= id6;
      iq7   <= iq6;

      m_tdata <= {to_duty(vc7, vcom7), to_duty(vb7, vcom7), to_duty(va7, vcom7),
                  iq7, id7};
    end
  end

  assign m_tvalid = v8;

endmodule

>>> rtl/foc_checker.sv
module foc_assert_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [foc_pkg::IN_W-1:0]   s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [foc_pkg::OUT_W-1:0]  m_tdata
);
  import foc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output side");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !s_tvalid |-> s_tready)
    else $error("stall with empty output");

endmodule

bind foc_transform_midpoint_svpwm_core foc_assert_checker u_foc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/foc_checker.sv
`timescale 1ns / 100ps

module foc_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [foc_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [foc_pkg::OUT_W-1:0] m_tdata,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [15:0] duty_c;
    logic [15:0] duty_b;
    logic [15:0] duty_a;
    logic [15:0] current_q;
    logic [15:0] current_d;
  } foc_result_t;

  foc_result_t expected_results[$];

  longint arc_table [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic logic [15:0] duty_of(longint d);
    if (d <= 0) return 16'h0000;
    if (d >= (longint'(1) << 36)) return 16'hFFFF;
    return 16'((d * 65535 + (longint'(1) << 35)) >>> 36);
  endfunction

  function automatic foc_result_t transform(logic [foc_pkg::IN_W-1:0] d);
    foc_result_t r;
    longint turn, x, y, z, dx, dy, sn, cs, ia, ib, ic, vd, vq, bus;
    longint ax, bx, na, nb, va, vb, vc, vmax, vmin, vcom;
    int quad;
    turn = longint'(d[15:0]) << 16;
    quad = int'(turn >> 30);
    z = turn & 64'h3FFFFFFF;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_table[i];
      end else begin
        x += dx; y -= dy; z += arc_table[i];
      end
    end
    case (quad)
      0: begin cs = x;  sn = y;  end
      1: begin cs = -y; sn = x;  end
      2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    ia = longint'($signed(d[31:16]));
    ib = longint'($signed(d[47:32]));
    ic = longint'($signed(d[63:48]));
    vd = longint'($signed(d[79:64]));
    vq = longint'($signed(d[95:80]));
    bus = longint'(d[110:96]);
    ax = ia * 256;
    bx = round_shift((ib - ic) * 619925131, 22);
    r.current_d = 16'(clamp16(round_shift(ax * cs + bx * sn, 38)));
    r.current_q = 16'(clamp16(round_shift(-ax * sn + bx * cs, 38)));
    na = 0;
    nb = 0;
    if (bus != 0) begin
      na = (vd * cs - vq * sn) / (bus * 1024);
      nb = (vd * sn + vq * cs) / (bus * 1024);
    end
    va = na * 65536;
    vb = -na * 32768 + nb * 56756;
    vc = -na * 32768 - nb * 56756;
    vmax = va > vb ? va : vb;
    if (vc > vmax) vmax = vc;
    vmin = va < vb ? va : vb;
    if (vc < vmin) vmin = vc;
    vcom = (vmax + vmin) >>> 1;
    r.duty_a = duty_of(va - vcom + (longint'(1) << 35));
    r.duty_b = duty_of(vb - vcom + (longint'(1) << 35));
    r.duty_c = duty_of(vc - vcom + (longint'(1) << 35));
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_results.size();

  always @(posedge clk) begin
    foc_result_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_results.push_back(transform(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          $display("unexpected transfer %h at %0t", m_tdata, $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.current_d != want.current_d) report("current_d", got.current_d, want.current_d);
          if (got.current_q != want.current_q) report("current_q", got.current_q, want.current_q);
          if (got.duty_a != want.duty_a) report("duty_a", got.duty_a, want.duty_a);
          if (got.duty_b != want.duty_b) report("duty_b", got.duty_b, want.duty_b);
          if (got.duty_c != want.duty_c) report("duty_c", got.duty_c, want.duty_c);
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [foc_pkg::IN_W-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [foc_pkg::OUT_W-1:0] m_tdata;
  int                        fail_count;
  int                        pending;
  bit                        calm;

  foc_transform_midpoint_svpwm_core dut (.*);

  foc_checker checker_i (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // output stall, with a calm stretch
  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [foc_pkg::IN_W-1:0] pack_item(logic [15:0] ang,
      logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] vd,
      logic [15:0] vq, logic [14:0] bus);
    return {1'b0, bus, vq, vd, c, b, a, ang};
  endfunction

  task automatic send(logic [foc_pkg::IN_W-1:0] d);
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    logic [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                               16'hFFFF, 16'h2000, 16'h3FFF, 16'h1555};
    rst = 1'b1;
    calm = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (angs[i]) send(pack_item(angs[i], 16'h7FFF, 16'h8000, 16'h7FFF,
                                     16'h7FFF, 16'h8000, 15'h0001));
    send(pack_item(16'h1234, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 15'h0000));
    send(pack_item(16'h9999, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0800, 15'h7FFF));
    send(pack_item(16'h5555, 16'h0100, 16'hFF00, 16'h0000, 16'h2000, 16'hE000, 15'h4000));
    send(pack_item(16'hAAAA, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 15'h7FFF));
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 450; n++) begin
      calm = (n >= 150 && n < 250);
      send(pack_item(16'($urandom), pick16(), pick16(), pick16(), pick16(), pick16(),
                     $urandom_range(3) == 0 ? 15'($urandom_range(32767)) :
                     15'($urandom_range(40000, 1) % 32768)));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
rtl/foc_pkg.sv
rtl/foc_cordic.sv
rtl/foc_div.sv
rtl/foc_transform_midpoint_svpwm_core.sv
rtl/foc_checker.sv
tb/sv/foc_checker.sv
tb/sv/tb_top.sv
